### sv/dvrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types, codes and helpers of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_AGE    = 2'd2,
    REQ_READ   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STS_APPLIED = 2'd0,
    STS_IGNORED = 2'd1,
    STS_FULL    = 2'd2,
    STS_UNUSED  = 2'd3
  } status_e;

  typedef enum logic {
    CFG_AGE_INIT = 1'b0,
    CFG_INFINITY = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_NET_RD,
    ST_NET_CHK,
    ST_AGE_RD,
    ST_AGE_CHK,
    ST_READ_RD,
    ST_READ_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] sender_address;
    logic [31:0] net_address;
    logic [5:0]  prefix_len;
    logic [31:0] distance;
    logic [3:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       read_net;
    logic [5:0]        read_prefix;
    logic [31:0]       read_distance;
    logic [31:0]       read_advertised;
    logic [31:0]       read_via;
    logic              read_direct;
    logic signed [7:0] read_decay;
    logic [4:0]        entry_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0]       host;
    logic [31:0]       net;
    logic [5:0]        prefix;
    logic signed [7:0] decay;
    logic [31:0]       distance;
    logic [31:0]       advertised;
    logic [31:0]       via;
    logic              direct;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

  function automatic logic [5:0] clamp_prefix(input logic [5:0] len);
    return (len > 6'd32) ? 6'd32 : len;
  endfunction

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'd0;
    end else if (len >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> len);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### sv/dvrt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dvrt_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dvrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### sv/distance_vector_route_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// distance_vector_route_table_top
// Ordered IPv4 route table in one entry RAM, walked by a sequencer.
// Each RAM entry visit passes through a read state and a check state.
// One request at a time; busy_o is high only while the sequencer is out of idle, and is low by the result beat.
// Result beats last one cycle; the receiver cannot stall.
// Reset empties the table and loads age init 5, infinity distance 16.
// ----------------------------------------------------------------------------
module distance_vector_route_table_top #(
  parameter int unsigned TableDepth = dvrt_pkg::DefaultDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire dvrt_pkg::req_t req_i,
  output logic                done_o,
  output dvrt_pkg::rsp_t      rsp_o,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_idx_i,
  input  wire logic [31:0]    cfg_wdata_i
);
  import dvrt_pkg::*;

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam logic [CW-1:0] DepthC = CW'(TableDepth);

  state_e      state_q, state_d;
  req_t        req_q, req_d;
  rsp_t        rsp_q, rsp_d;
  logic        done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d, ptr_q, ptr_d, wptr_q, wptr_d;
  logic [31:0] cost_q, cost_d;
  logic [6:0]  age_init_q;
  logic [31:0] inf_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata, ram_rdata;
  logic [CW-1:0] ptr_inc;
  logic signed [8:0] dec;
  logic signed [8:0] limit;

  dvrt_ram #(.Width(EntryWidth), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ptr_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      done_q     <= 1'b0;
      cnt_q      <= '0;
      ptr_q      <= '0;
      wptr_q     <= '0;
      age_init_q <= 7'd5;
      inf_q      <= 32'd16;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      wptr_q  <= wptr_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_AGE_INIT: age_init_q <= cfg_wdata_i[6:0];
          CFG_INFINITY: inf_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rsp_q  <= rsp_d;
    cost_q <= cost_d;
  end

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    cost_d    = cost_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    wptr_d    = wptr_q;
    done_d    = 1'b0;
    rsp_d     = '0;
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AW-1:0];
    ram_wdata = ram_rdata;
    ptr_inc   = ptr_q + CW'(1);
    dec       = 9'(ram_rdata.decay) - 9'sd1;
    limit     = -$signed({2'b00, age_init_q});

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          ptr_d = '0;
          wptr_d = '0;
          case (req_type_e'(req_i.req_type))
            REQ_ADD: begin
              done_d = 1'b1;
              if (cnt_q >= DepthC) begin
                rsp_d.status = STS_FULL;
              end else begin
                ram_we               = 1'b1;
                ram_waddr            = cnt_q[AW-1:0];
                ram_wdata.host       = req_i.sender_address;
                ram_wdata.net        = req_i.sender_address &
                                       prefix_mask(clamp_prefix(req_i.prefix_len));
                ram_wdata.prefix     = clamp_prefix(req_i.prefix_len);
                ram_wdata.decay      = $signed({1'b0, age_init_q});
                ram_wdata.distance   = req_i.distance;
                ram_wdata.advertised = req_i.distance;
                ram_wdata.via        = 32'd0;
                ram_wdata.direct     = 1'b1;
                cnt_d                = cnt_q + CW'(1);
                rsp_d.status         = STS_APPLIED;
              end
            end
            REQ_UPDATE: begin
              if (req_i.distance == inf_q || cnt_q == '0) begin
                done_d       = 1'b1;
                rsp_d.status = STS_IGNORED;
              end else begin
                state_d = ST_FIND_RD;
              end
            end
            REQ_AGE: begin
              if (cnt_q == '0) begin
                done_d       = 1'b1;
                rsp_d.status = STS_APPLIED;
              end else begin
                state_d = ST_AGE_RD;
              end
            end
            default: begin
              if (32'(req_i.entry_index) < 32'(cnt_q)) begin
                ptr_d   = CW'(req_i.entry_index);
                state_d = ST_READ_RD;
              end else begin
                done_d       = 1'b1;
                rsp_d.status = STS_UNUSED;
              end
            end
          endcase
        end
      end
      ST_FIND_RD: state_d = ST_FIND_CHK;
      ST_FIND_CHK: begin
        if ((req_q.sender_address & prefix_mask(ram_rdata.prefix)) == ram_rdata.net &&
            req_q.sender_address != ram_rdata.host) begin
          if (!ram_rdata.direct) begin
            done_d       = 1'b1;
            rsp_d.status = STS_IGNORED;
            state_d      = ST_IDLE;
          end else begin
            ram_we               = 1'b1;
            ram_wdata.advertised = ram_rdata.distance;
            cost_d               = req_q.distance + ram_rdata.distance;
            ptr_d                = '0;
            state_d              = ST_NET_RD;
          end
        end else begin
          ptr_d = ptr_inc;
          if (ptr_inc == cnt_q) begin
            done_d       = 1'b1;
            rsp_d.status = STS_IGNORED;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_FIND_RD;
          end
        end
      end
      ST_NET_RD: state_d = ST_NET_CHK;
      ST_NET_CHK: begin
        if (ram_rdata.net == req_q.net_address) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (cost_q > ram_rdata.distance || ram_rdata.direct) begin
            rsp_d.status = STS_IGNORED;
          end else begin
            ram_we               = 1'b1;
            ram_wdata.decay      = $signed({1'b0, age_init_q});
            ram_wdata.distance   = cost_q;
            ram_wdata.advertised = cost_q;
            ram_wdata.via        = req_q.sender_address;
            rsp_d.status         = STS_APPLIED;
          end
        end else begin
          ptr_d = ptr_inc;
          if (ptr_inc == cnt_q) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
            if (cnt_q >= DepthC) begin
              rsp_d.status = STS_FULL;
            end else begin
              ram_we               = 1'b1;
              ram_waddr            = cnt_q[AW-1:0];
              ram_wdata.host       = req_q.net_address;
              ram_wdata.net        = req_q.net_address &
                                     prefix_mask(clamp_prefix(req_q.prefix_len));
              ram_wdata.prefix     = clamp_prefix(req_q.prefix_len);
              ram_wdata.decay      = $signed({1'b0, age_init_q});
              ram_wdata.distance   = cost_q;
              ram_wdata.advertised = cost_q;
              ram_wdata.via        = req_q.sender_address;
              ram_wdata.direct     = 1'b0;
              cnt_d                = cnt_q + CW'(1);
              rsp_d.status         = STS_APPLIED;
            end
          end else begin
            state_d = ST_NET_RD;
          end
        end
      end
      ST_AGE_RD: state_d = ST_AGE_CHK;
      ST_AGE_CHK: begin
        ram_waddr = wptr_q[AW-1:0];
        if (ram_rdata.direct) begin
          ram_we = 1'b1;
          wptr_d = wptr_q + CW'(1);
        end else begin
          ram_wdata.decay = dec[7:0];
          if (dec <= 9'sd0) begin
            ram_wdata.advertised = inf_q;
          end
          if (dec >= limit) begin
            ram_we = 1'b1;
            wptr_d = wptr_q + CW'(1);
          end
        end
        ptr_d = ptr_inc;
        if (ptr_inc == cnt_q) begin
          cnt_d        = wptr_d;
          done_d       = 1'b1;
          rsp_d.status = STS_APPLIED;
          state_d      = ST_IDLE;
        end else begin
          state_d = ST_AGE_RD;
        end
      end
      ST_READ_RD: state_d = ST_READ_OUT;
      ST_READ_OUT: begin
        done_d                = 1'b1;
        rsp_d.status          = STS_APPLIED;
        rsp_d.read_net        = ram_rdata.net;
        rsp_d.read_prefix     = ram_rdata.prefix;
        rsp_d.read_distance   = ram_rdata.distance;
        rsp_d.read_advertised = ram_rdata.advertised;
        rsp_d.read_via        = ram_rdata.via;
        rsp_d.read_direct     = ram_rdata.direct;
        rsp_d.read_decay      = ram_rdata.decay;
        state_d               = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    rsp_d.entry_count = 5'(cnt_d);
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
`default_nettype wire

### sim/tb_distance_vector_route_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distance_vector_route_table_top
// Self-checking bench for the route table. A scoreboard class keeps its own
// copy of the table and predicts the response of every accepted request;
// responses are checked field by field in order. A directed prologue covers
// the special cases, then constrained-by-hand random traffic with three
// sender idling profiles and register settings changed between phases.
// ----------------------------------------------------------------------------
module tb_distance_vector_route_table_top;
  import dvrt_pkg::*;

  localparam int Depth = 16;

  class route_scoreboard;
    logic [6:0]        decay_rst;
    logic [31:0]       inf_dist;
    logic [31:0]       host   [Depth];
    logic [31:0]       net    [Depth];
    logic [5:0]        prefix [Depth];
    int                decay  [Depth];
    logic [31:0]       route_dist [Depth];
    logic [31:0]       adv    [Depth];
    logic [31:0]       via    [Depth];
    logic              direct [Depth];
    int                used;
    rsp_t              pending[$];
    int                errors;
    int                n_checked;
    int                n_status[4];

    function new();
      decay_rst = 7'd5;
      inf_dist  = 32'd16;
      used      = 0;
      errors    = 0;
      n_checked = 0;
    endfunction

    function logic [31:0] mask_of(logic [5:0] len);
      if (len == 6'd0) return 32'd0;
      if (len >= 6'd32) return 32'hFFFF_FFFF;
      return ~(32'hFFFF_FFFF >> len);
    endfunction

    function int direct_count();
      int c;
      c = 0;
      for (int i = 0; i < used; i++) if (direct[i]) c++;
      return c;
    endfunction

    function status_e append(logic [31:0] h, logic [5:0] len, logic [31:0] d,
                             logic [31:0] v, logic dir);
      if (used >= Depth) return STS_FULL;
      host[used]       = h;
      net[used]        = h & mask_of(len);
      prefix[used]     = len;
      decay[used]      = decay_rst;
      route_dist[used] = d;
      adv[used]        = d;
      via[used]        = v;
      direct[used]     = dir;
      used++;
      return STS_APPLIED;
    endfunction

    function status_e advertise(req_t r, logic [5:0] len);
      int f, i;
      logic [31:0] cost;
      if (r.distance == inf_dist) return STS_IGNORED;
      for (f = 0; f < used; f++)
        if ((r.sender_address & mask_of(prefix[f])) == net[f] &&
            r.sender_address != host[f]) break;
      if (f >= used || !direct[f]) return STS_IGNORED;
      adv[f] = route_dist[f];
      cost = r.distance + route_dist[f];
      for (i = 0; i < used; i++) if (net[i] == r.net_address) break;
      if (i < used) begin
        if (cost > route_dist[i] || direct[i]) return STS_IGNORED;
        decay[i]      = decay_rst;
        route_dist[i] = cost;
        adv[i]        = cost;
        via[i]        = r.sender_address;
        return STS_APPLIED;
      end
      return append(r.net_address, len, cost, r.sender_address, 1'b0);
    endfunction

    function void age_all();
      int w;
      w = 0;
      for (int i = 0; i < used; i++) begin
        if (!direct[i]) begin
          decay[i]--;
          if (decay[i] <= 0) adv[i] = inf_dist;
        end
      end
      for (int i = 0; i < used; i++) begin
        if (!direct[i] && decay[i] < -int'(decay_rst)) continue;
        host[w] = host[i]; net[w] = net[i]; prefix[w] = prefix[i];
        decay[w] = decay[i]; route_dist[w] = route_dist[i]; adv[w] = adv[i];
        via[w] = via[i]; direct[w] = direct[i];
        w++;
      end
      used = w;
    endfunction

    function void note_request(req_t r);
      rsp_t    e;
      status_e st;
      logic [5:0] len;
      e   = '0;
      st  = STS_APPLIED;
      len = (r.prefix_len > 6'd32) ? 6'd32 : r.prefix_len;
      case (req_type_e'(r.req_type))
        REQ_ADD:    st = append(r.sender_address, len, r.distance, 32'd0, 1'b1);
        REQ_UPDATE: st = advertise(r, len);
        REQ_AGE:    age_all();
        default: begin
          if (int'(r.entry_index) < used) begin
            e.read_net        = net[r.entry_index];
            e.read_prefix     = prefix[r.entry_index];
            e.read_distance   = route_dist[r.entry_index];
            e.read_advertised = adv[r.entry_index];
            e.read_via        = via[r.entry_index];
            e.read_direct     = direct[r.entry_index];
            e.read_decay      = decay[r.entry_index][7:0];
          end else begin
            st = STS_UNUSED;
          end
        end
      endcase
      e.status      = st;
      e.entry_count = used[4:0];
      n_status[st]++;
      pending.push_back(e);
    endfunction

    function void check_response(rsp_t a);
      rsp_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response beat: %p", a);
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (a.status !== e.status || a.read_net !== e.read_net ||
          a.read_prefix !== e.read_prefix || a.read_distance !== e.read_distance ||
          a.read_advertised !== e.read_advertised || a.read_via !== e.read_via ||
          a.read_direct !== e.read_direct || a.read_decay !== e.read_decay ||
          a.entry_count !== e.entry_count) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at response %0d", n_checked);
          $display("  exp %p", e);
          $display("  got %p", a);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  req_t        req_i;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  route_scoreboard sb;
  int          idle_cycles;
  int          gap_pct;
  logic [31:0] net_pool[24];

  distance_vector_route_table_top dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .done_o, .rsp_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_response(rsp_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(req_t r);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(r);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_AGE_INIT) sb.decay_rst = val[6:0];
    else sb.inf_dist = val;
  endtask

  function automatic req_t mk(req_type_e t, logic [31:0] s, logic [31:0] n,
                              logic [5:0] len, logic [31:0] d, logic [3:0] idx);
    req_t r;
    r.req_type = t; r.sender_address = s; r.net_address = n;
    r.prefix_len = len; r.distance = d; r.entry_index = idx;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick, dirs[$], d;
    logic [31:0] m;
    r = mk(REQ_READ, $urandom, $urandom, 6'($urandom_range(63)), $urandom,
           4'($urandom_range(15)));
    pick = $urandom_range(99);
    if (pick < 8) begin
      // add only while few direct nets exist, or to hit a full table
      if (sb.direct_count() < 5 || sb.used == Depth) begin
        r.req_type = REQ_ADD;
        r.prefix_len = 6'($urandom_range(32, 16));
        r.distance = $urandom_range(9);
      end
    end else if (pick < 60) begin
      r.req_type = REQ_UPDATE;
      for (int i = 0; i < sb.used; i++) if (sb.direct[i]) dirs.push_back(i);
      if (dirs.size() > 0 && $urandom_range(9) > 0) begin
        d = dirs[$urandom_range(dirs.size() - 1)];
        m = sb.mask_of(sb.prefix[d]);
        r.sender_address = sb.net[d] | ($urandom & ~m);
        if (r.sender_address == sb.host[d]) r.sender_address ^= ~m & 32'h1;
        r.net_address = ($urandom_range(9) == 0) ? sb.net[d] :
                        net_pool[$urandom_range(23)];
        r.prefix_len = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'd24;
        case ($urandom_range(9))
          0:       r.distance = sb.inf_dist;
          1:       r.distance = $urandom;
          default: r.distance = $urandom_range(12);
        endcase
      end
    end else if (pick < 75) begin
      r.req_type = REQ_AGE;
    end
    return r;
  endfunction

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_AGE_INIT;
    cfg_wdata_i = '0;
    idle_cycles = 0;
    gap_pct     = 0;
    for (int i = 0; i < 24; i++) net_pool[i] = {8'd20 + 8'(i), 8'($urandom), 16'd0};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed prologue
    send(mk(REQ_READ, '0, '0, '0, '0, 4'd0));
    send(mk(REQ_ADD, 32'h0A00_0001, '0, 6'd24, 32'd1, '0));
    send(mk(REQ_ADD, 32'hC0A8_0101, '0, 6'd40, 32'd0, '0));
    send(mk(REQ_ADD, 32'hFFFF_FFFF, '0, 6'd0, 32'hFFFF_FFFF, '0));
    send(mk(REQ_UPDATE, 32'h0A00_0002, 32'h1400_0000, 6'd8, 32'd16, '0));
    send(mk(REQ_UPDATE, 32'h0A00_0001, 32'h1500_0000, 6'd8, 32'd3, '0));
    send(mk(REQ_UPDATE, 32'h0A00_0002, 32'h1400_0000, 6'd8, 32'd2, '0));
    send(mk(REQ_UPDATE, 32'h0A00_0002, 32'h1400_0000, 6'd8, 32'd1, '0));
    send(mk(REQ_UPDATE, 32'h0A00_0002, 32'h1400_0000, 6'd8, 32'd5, '0));
    send(mk(REQ_UPDATE, 32'h0A00_0003, 32'h0A00_0000, 6'd24, 32'd0, '0));
    send(mk(REQ_UPDATE, 32'h0B00_0005, 32'h1600_0000, 6'd0, 32'd4, '0));
    send(mk(REQ_UPDATE, 32'h0A00_0002, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFF0, '0));
    send(mk(REQ_AGE, '0, '0, '0, '0, '0));
    send(mk(REQ_AGE, '0, '0, '0, '0, '0));
    for (int i = 0; i < 7; i++) send(mk(REQ_READ, '0, '0, '0, '0, 4'(i)));
    send(mk(REQ_READ, '0, '0, '0, '0, 4'd15));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin write_reg(CFG_AGE_INIT, 32'd3);   write_reg(CFG_INFINITY, 32'd16); end
        1: begin write_reg(CFG_AGE_INIT, 32'd1);   write_reg(CFG_INFINITY, 32'hFFFF_FFFF); end
        default: begin
          write_reg(CFG_AGE_INIT, 32'd100);
          write_reg(CFG_INFINITY, 32'd1);
        end
      endcase
      gap_pct = (phase == 0) ? 33 : (phase == 1) ? 87 : 0;
      for (int n = 0; n < 580; n++) send(random_request());
    end

    drain();
    repeat (100) @(posedge clk_i);
    $display("covered %0d responses: applied %0d, ignored %0d, full %0d, unused index %0d",
             sb.n_checked, sb.n_status[STS_APPLIED], sb.n_status[STS_IGNORED],
             sb.n_status[STS_FULL], sb.n_status[STS_UNUSED]);
    $display("three register settings and three sender idling profiles, %0d errors",
             sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
sv/dvrt_pkg.sv
sv/dvrt_ram.sv
sv/distance_vector_route_table_top.sv
sim/tb_distance_vector_route_table_top.sv
